/* hw/rtl/ripr_pkg.sv */
// ----------------------------------------------------------------------------
// ripr_pkg: shared constants for the rotate-in-place rate profile
// Field widths, register indexes and fixed constants of the rate profiler.
// ----------------------------------------------------------------------------
package ripr_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_ACCEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 2'd2;

  // field widths
  localparam int HEAD_W  = 15;  // heading, signed
  localparam int ERR_W   = 17;  // heading error before wrapping, signed
  localparam int RATE_W  = 16;  // signed rate
  localparam int MAG_W   = 15;  // rate or error magnitude
  localparam int TICK_W  = 16;  // tick period, Q0.16
  localparam int MUL_B_W = 16;  // second operand of the shared multiplier

  // squared rate and the divider that works on it
  localparam int W2_W      = 2 * MAG_W;
  localparam int DEN_W     = 16;
  localparam int DIV_STEPS = W2_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [MAG_W-1:0] RATE_MAX = 15'd32767;

  // pi in Q32, rounded to nearest
  localparam longint PI_Q32 = 64'sd13493037705;

endpackage

/* hw/rtl/rotate_in_place_rate_profile.sv */
// ----------------------------------------------------------------------------
// rotate_in_place_rate_profile: trapezoidal angular rate profiler
// One transaction per control tick: headings in, signed rate command out.
// ----------------------------------------------------------------------------
// The slave stream carries the measured and target heading of one tick; the
// master stream returns the new rate command with the done flag in tuser.
// The config port sets rate limit, acceleration and tick period; write it
// only while no tick is in flight.
// One tick is worked by a small sequencer around one shared multiplier and
// a one-bit-per-cycle restoring divider. The sequencer steps through wrap,
// threshold and compare, then, for the corrected braking rate, divider set-up
// and the divider's 30 steps (skipped for a zero braking divisor), then tick
// and apply. Wrap repeats once per 2*pi correction of the error, of which
// there is at most one with 12 fraction bits. The sequencer goes back to idle,
// ready for the next tick, when the result is registered.
// The result register frees the sequencer: a new tick is taken while the
// previous result waits, and only the final step holds off when the
// receiver stalls with a result still unread.
// Reset clears the stored rate, restores the default registers and empties
// the output.
// ----------------------------------------------------------------------------
module rotate_in_place_rate_profile
  import ripr_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // [14:0] heading_now, [29:15] heading_goal
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [15:0] rate_command
  output logic                  m_tuser,   // [0] rotation_done
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam longint OneQ  = longint'(1) << FRAC_BITS;
  localparam longint TolQl = (2 * OneQ + 50) / 100;
  localparam longint OfsQl = (OneQ + 50) / 100;
  localparam longint SlwQl = (3 * OneQ + 50) / 100;
  localparam longint HlfQl = OneQ / 2;
  localparam longint PiQ   = (PI_Q32 + (longint'(1) << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam longint TwoPi = 2 * PiQ;

  localparam int CapW = $clog2(longint'(RATE_MAX) + HlfQl + 1);
  localparam int MaW  = (CapW > 16) ? CapW : 16;
  localparam int PW   = MaW + MUL_B_W;
  localparam int NwW  = MaW + 3;

  localparam logic [MAG_W-1:0] TolQ  = MAG_W'(TolQl);
  localparam logic [MAG_W-1:0] OfsQ  = MAG_W'(OfsQl);
  localparam logic [MAG_W-1:0] SlowQ = MAG_W'(SlwQl);
  localparam logic [CapW-1:0]  HalfQ = CapW'(HlfQl);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WRAP   = 4'd1;
  localparam logic [3:0] S_THR    = 4'd2;
  localparam logic [3:0] S_CMP    = 4'd3;
  localparam logic [3:0] S_DIVSET = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_TICK   = 4'd6;
  localparam logic [3:0] S_APPLY  = 4'd7;

  logic [3:0]               state;
  logic [MAG_W-1:0]         rate_limit;
  logic [MAG_W-1:0]         rate_accel;
  logic [TICK_W-1:0]        tick_period;
  logic signed [RATE_W-1:0] angular_rate;

  logic signed [ERR_W-1:0]  err;
  logic [MAG_W-1:0]         aerr;
  logic [MAG_W-1:0]         aw;
  logic [W2_W-1:0]          w2;
  logic [PW-1:0]            prod;
  logic                     up;
  logic [CapW-1:0]          dec;
  logic [DEN_W-1:0]         den;
  logic [DEN_W-1:0]         rem;
  logic [W2_W-1:0]          q_sr;
  logic [CNT_W-1:0]         cnt;

  logic [MaW-1:0]           mul_a;
  logic [MUL_B_W-1:0]       mul_b;

  // wrapping
  logic signed [63:0]       err_l;
  logic                     err_hi;
  logic                     err_lo;
  logic signed [ERR_W-1:0]  err_neg;
  logic signed [ERR_W-1:0]  err_dn;
  logic signed [ERR_W-1:0]  err_upw;

  // threshold compare
  logic signed [MAG_W+1:0]  x1;
  logic                     phase_acc;

  // braking divisor
  logic [PW-1:0]            lead_sh;
  logic signed [MAG_W+2:0]  dsum;
  logic signed [MAG_W+2:0]  dabs;
  logic [MAG_W-1:0]         div_mag;
  logic [CapW-1:0]          cap;

  // divider step
  logic [DEN_W:0]           rem_sh;
  logic                     ge;
  logic [W2_W-1:0]          q_next;
  logic [CapW-1:0]          q_min;

  // final step
  logic [PW:0]              t_full;
  logic [MaW:0]             t;
  logic signed [NwW-1:0]    aw_ext;
  logic signed [NwW-1:0]    t_ext;
  logic signed [NwW-1:0]    nw;
  logic [MAG_W-1:0]         mag;
  logic                     done;
  logic signed [RATE_W-1:0] rate_new;
  logic                     commit;

  assign s_tready = (state == S_IDLE);
  assign commit   = (state == S_APPLY) && (!m_tvalid || m_tready);

  always_comb begin
    err_l   = longint'(err);
    err_hi  = err_l > PiQ;
    err_lo  = err_l <= -PiQ;
    err_dn  = ERR_W'(err_l - TwoPi);
    err_upw = ERR_W'(err_l + TwoPi);
    err_neg = -err;

    x1 = $signed({2'b00, aerr}) - $signed({2'b00, TolQ}) + $signed((MAG_W+2)'(1));
    phase_acc = (rate_accel != '0) && (aerr >= TolQ) && (PW'(w2) < prod);

    lead_sh = (prod + PW'(HalfQ)) >> FRAC_BITS;
    dsum    = $signed({3'b000, aerr}) - $signed({2'b00, lead_sh[DEN_W-1:0]})
              - $signed({3'b000, OfsQ});
    dabs    = dsum[MAG_W+2] ? -dsum : dsum;
    div_mag = dabs[MAG_W-1:0];
    cap     = CapW'(rate_accel) + HalfQ;

    rem_sh = {rem, q_sr[W2_W-1]};
    ge     = rem_sh >= {1'b0, den};
    q_next = {q_sr[W2_W-2:0], ge};
    q_min  = (q_next > W2_W'(cap)) ? cap : CapW'(q_next);

    t_full = {1'b0, prod} + (PW+1)'(32768);
    t      = t_full[PW:16];
    aw_ext = $signed({{(NwW-MAG_W){1'b0}}, aw});
    t_ext  = $signed({2'b00, t});
    nw     = up ? (aw_ext + t_ext) : (aw_ext - t_ext);
    if (nw < $signed({{(NwW-MAG_W){1'b0}}, TolQ})) begin
      mag = TolQ;
    end else if (nw > $signed({{(NwW-MAG_W){1'b0}}, RATE_MAX})) begin
      mag = RATE_MAX;
    end else begin
      mag = nw[MAG_W-1:0];
    end
    done = (aerr < TolQ) && (mag < SlowQ);
    if (done) begin
      rate_new = '0;
    end else if (err[ERR_W-1] || err == '0) begin
      rate_new = -$signed({1'b0, mag});
    end else begin
      rate_new = $signed({1'b0, mag});
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state) inside
      S_WRAP: begin
        mul_a = MaW'(aw);
        mul_b = MUL_B_W'(aw);
      end
      S_THR: begin
        mul_a = MaW'(x1[MAG_W:0]);
        mul_b = {rate_accel, 1'b0};
      end
      S_CMP: begin
        mul_a = MaW'(aw);
        mul_b = MUL_B_W'(TolQ);
      end
      // hold the step product while the result waits for the receiver
      S_TICK, S_APPLY: begin
        mul_a = MaW'(dec);
        mul_b = tick_period;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PW'(mul_a) * PW'(mul_b);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit  <= 15'd4096;
      rate_accel  <= 15'd2048;
      tick_period <= 16'd3277;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RATE_LIMIT:  rate_limit  <= cfg_data[MAG_W-1:0];
        CFG_RATE_ACCEL:  rate_accel  <= cfg_data[MAG_W-1:0];
        CFG_TICK_PERIOD: tick_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      angular_rate <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (!err_hi && !err_lo) begin
            state <= S_THR;
          end
        end
        S_THR: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (phase_acc) begin
            state <= S_TICK;
          end else if (aerr > TolQ) begin
            state <= S_DIVSET;
          end else begin
            state <= S_TICK;
          end
        end
        S_DIVSET: begin
          if (div_mag == '0) begin
            state <= S_TICK;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_TICK;
          end
        end
        S_TICK: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (commit) begin
            angular_rate <= rate_new;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        err <= $signed({s_tdata[2*HEAD_W-1], s_tdata[2*HEAD_W-1], s_tdata[2*HEAD_W-1:HEAD_W]})
               - $signed({s_tdata[HEAD_W-1], s_tdata[HEAD_W-1], s_tdata[HEAD_W-1:0]});
        aw  <= angular_rate[RATE_W-1] ? MAG_W'(-angular_rate) : MAG_W'(angular_rate);
      end
      S_WRAP: begin
        aerr <= err[ERR_W-1] ? MAG_W'(err_neg) : MAG_W'(err);
        // fold the error by one turn per cycle until it lies in (-pi, pi]
        if (err_hi) begin
          err <= err_dn;
        end else if (err_lo) begin
          err <= err_upw;
        end
      end
      S_THR: begin
        w2 <= prod[W2_W-1:0];
      end
      S_CMP: begin
        // accelerate below the limit, otherwise step down by the configured acceleration
        dec <= CapW'(rate_accel);
        up  <= phase_acc && (aw < rate_limit);
      end
      S_DIVSET: begin
        dec  <= cap;
        den  <= {div_mag, 1'b0};
        rem  <= '0;
        q_sr <= w2;
        cnt  <= '0;
      end
      S_DIV: begin
        rem  <= ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
        q_sr <= q_next;
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          dec <= q_min;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= rate_new;
      m_tuser <= done;
    end
  end

  // a finished rotation always commands zero rate
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("done raised with non-zero rate");

  // an active command is never zero and never the negative extreme
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata != '0) && (m_tdata != 16'h8000))
    else $error("active rate command out of range");

  // the divider never runs on a zero divisor
  assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> den != '0)
    else $error("divide by zero");

  // the stored rate changes only when a result is committed
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (angular_rate != $past(angular_rate)) |-> $past(commit))
    else $error("stored rate changed outside commit");

  // a new tick is only taken from idle and starts with wrapping
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_WRAP)
    else $error("accepted tick did not start");

endmodule

/* dv/tb_rotate_in_place_rate_profile.sv */
// ----------------------------------------------------------------------------
// tb_rotate_in_place_rate_profile: self-checking bench for the rate profiler
// Heading pairs go in on the slave stream with random gaps and one long
// output stall. Each rate command is predicted by a local fixed-point profile
// and checked in order on the master stream. The run covers directed corner
// ticks and then random rotations under several limit, acceleration and tick
// settings.
// ----------------------------------------------------------------------------
module tb_rotate_in_place_rate_profile;
  import ripr_pkg::*;

  localparam int     FRAC     = 12;
  localparam longint UNIT     = longint'(1) << FRAC;
  localparam longint TOL      = (2 * UNIT + 50) / 100;
  localparam longint OFS      = (UNIT + 50) / 100;
  localparam longint SLOW     = (3 * UNIT + 50) / 100;
  localparam longint HALF     = UNIT / 2;
  localparam longint PI_FX    = (PI_Q32 + (longint'(1) << (31 - FRAC))) >>> (32 - FRAC);
  localparam longint RATE_SAT = 32767;
  localparam int     HEAD_MAX = int'(PI_FX);

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 6;
  localparam int PHASE_TICKS  = 75;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 60;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate;
    logic                     done;
  } rate_cmd_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_TICK, ROW_ZERO_DIV} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        a;     // heading_now, or register index
    int        b;     // heading_goal, or register value
    bit        lit;   // expected command typed in
    int        rate;
    bit        done;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;   // [14:0] heading_now, [29:15] heading_goal
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;        // [15:0] rate_command
  logic                  m_tuser;        // [0] rotation_done
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // profile state and registers as the block should hold them
  longint lim_cfg  = 4096;
  longint acc_cfg  = 2048;
  longint tick_cfg = 3277;
  longint pred_rate = 0;

  rate_cmd_t cmd_queue [$];
  int  errors = 0;
  int  cycle_count = 0;
  int  ticks_sent = 0;
  int  results_seen = 0;
  int  reg_writes = 0;
  int  n_accel = 0, n_corr = 0, n_zdiv = 0, n_plain = 0, n_sat = 0, n_done = 0;
  bit  send_quiet = 1'b0;

  dir_row_t dir_rows [30] = '{
    '{ROW_TICK, 0, 0, 1'b1, 0, 1'b1},
    '{ROW_TICK, 0, 12868, 1'b1, 102, 1'b0},
    '{ROW_TICK, 0, -12868, 1'b1, 204, 1'b0},      // wraps to +pi
    '{ROW_TICK, -16384, 16383, 1'b0, 0, 1'b0},
    '{ROW_TICK, 16383, -16384, 1'b0, 0, 1'b0},
    '{ROW_TICK, 100, 100, 1'b0, 0, 1'b0},         // zero error
    '{ROW_TICK, 0, 82, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, -81, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, 83, 1'b0, 0, 1'b0},
    '{ROW_CFG, CFG_RATE_LIMIT, 32767, 1'b0, 0, 1'b0},
    '{ROW_CFG, CFG_TICK_PERIOD, 65535, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, 12000, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, 12000, 1'b0, 0, 1'b0},
    '{ROW_ZERO_DIV, 0, 0, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, 2000, 1'b0, 0, 1'b0},
    '{ROW_CFG, CFG_RATE_ACCEL, 0, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, 12868, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, 50, 1'b0, 0, 1'b0},
    '{ROW_CFG, CFG_RATE_ACCEL, 32767, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, 0, 1'b1, 0, 1'b1},
    '{ROW_CFG, CFG_TICK_PERIOD, 1, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, 12868, 1'b1, 82, 1'b0},
    '{ROW_CFG, CFG_TICK_PERIOD, 65535, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, 12868, 1'b1, 32767, 1'b0},     // rate saturates
    '{ROW_CFG, CFG_RATE_LIMIT, 1, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, 12868, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, -5000, 1'b0, 0, 1'b0},
    '{ROW_CFG, CFG_RATE_ACCEL, 1, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, 12868, 1'b0, 0, 1'b0},
    '{ROW_TICK, 0, -12867, 1'b0, 0, 1'b0}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rotate_in_place_rate_profile #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint scale_by_tick(longint a);
    return (a * tick_cfg + (longint'(1) << 15)) >>> 16;
  endfunction

  // one control tick of the trapezoidal profile; advances the stored rate
  function automatic rate_cmd_t profile_step(logic signed [HEAD_W-1:0] now,
                                             logic signed [HEAD_W-1:0] goal);
    longint    err, aerr, aw, w2, lead, dvs, cap, dec, nw;
    bit        far;
    rate_cmd_t cmd;
    err = longint'(goal) - longint'(now);
    while (err > PI_FX) err -= 2 * PI_FX;
    while (err <= -PI_FX) err += 2 * PI_FX;
    aerr = mag(err);
    aw   = mag(pred_rate);
    w2   = aw * aw;
    // no acceleration means an unbounded braking distance
    far  = (acc_cfg != 0) && (aerr >= w2 / (2 * acc_cfg) + TOL);
    if (far) begin
      nw = (aw < lim_cfg) ? aw + scale_by_tick(acc_cfg) : aw - scale_by_tick(acc_cfg);
      n_accel++;
    end else if (aerr > TOL) begin
      lead = (aw * TOL + (UNIT >>> 1)) >>> FRAC;
      dvs  = mag(aerr - lead - OFS);
      cap  = acc_cfg + HALF;
      if (dvs == 0) begin
        dec = cap;
        n_zdiv++;
      end else begin
        dec = w2 / (2 * dvs);
        if (dec > cap) dec = cap;
      end
      nw = aw - scale_by_tick(dec);
      n_corr++;
    end else begin
      nw = aw - scale_by_tick(acc_cfg);
      n_plain++;
    end
    if (nw < TOL) nw = TOL;
    if (nw > RATE_SAT) begin
      nw = RATE_SAT;
      n_sat++;
    end
    if (err <= 0) nw = -nw;
    cmd.done = 1'b0;
    if (aerr < TOL && mag(nw) < SLOW) begin
      nw = 0;
      cmd.done = 1'b1;
      n_done++;
    end
    pred_rate = nw;
    cmd.rate  = nw[RATE_W-1:0];
    return cmd;
  endfunction

  // error magnitude at which the corrected braking divisor is zero
  function automatic int zero_div_error();
    return int'(((mag(pred_rate) * TOL + (UNIT >>> 1)) >>> FRAC) + OFS);
  endfunction

  function automatic int wrap_heading(int h);
    while (h > HEAD_MAX) h -= 2 * HEAD_MAX;
    while (h < -HEAD_MAX) h += 2 * HEAD_MAX;
    return h;
  endfunction

  function automatic int raw_heading();
    logic [31:0] raw;
    raw = $urandom;
    return raw[14] ? int'(raw[14:0]) - 32768 : int'(raw[14:0]);
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_setting(int lo, int hi, int mid_lo, int mid_hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return lo;
    if (r < 30) return hi;
    return $urandom_range(mid_lo, mid_hi);
  endfunction

  task automatic send_tick(int now, int goal, bit use_lit, int lit_rate, bit lit_done);
    logic signed [HEAD_W-1:0] hn, hg;
    rate_cmd_t                cmd;
    int                       gap;
    hn = now[HEAD_W-1:0];
    hg = goal[HEAD_W-1:0];
    s_tdata  <= {2'b00, hg, hn};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cmd = profile_step(hn, hg);
    if (use_lit) begin
      cmd.rate = lit_rate[RATE_W-1:0];
      cmd.done = lit_done;
    end
    cmd_queue.push_back(cmd);
    ticks_sent++;
    if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and wait for every outstanding command
  task automatic settle();
    s_tvalid <= 1'b0;
    while (cmd_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RATE_LIMIT:  lim_cfg  = value & 32'h7FFF;
      CFG_RATE_ACCEL:  acc_cfg  = value & 32'h7FFF;
      CFG_TICK_PERIOD: tick_cfg = value & 32'hFFFF;
      default: ;
    endcase
    reg_writes++;
  endtask

  initial begin : stimulus
    int now, goal, e, len, sent, r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          settle();
          write_reg(dir_rows[i].a[CFG_IDX_W-1:0], dir_rows[i].b);
        end
        ROW_TICK: begin
          send_tick(dir_rows[i].a, dir_rows[i].b, dir_rows[i].lit,
                    dir_rows[i].rate, dir_rows[i].done);
        end
        ROW_ZERO_DIV: begin
          send_tick(dir_rows[i].a, dir_rows[i].a + zero_div_error(), 1'b0, 0, 1'b0);
        end
        default: ;
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_reg(CFG_RATE_LIMIT, pick_setting(1, 32767, 1000, 12000));
      write_reg(CFG_RATE_ACCEL,
                ($urandom_range(0, 19) == 0) ? 0 : pick_setting(1, 32767, 500, 8000));
      write_reg(CFG_TICK_PERIOD, pick_setting(1, 65535, 300, 8000));
      sent = 0;
      while (sent < PHASE_TICKS) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          // rotation towards a fixed goal; heading follows the commanded rate
          now  = $urandom_range(0, 2 * HEAD_MAX) - HEAD_MAX;
          e    = $urandom_range(0, HEAD_MAX);
          if ($urandom_range(0, 1)) e = -e;
          goal = wrap_heading(now + e);
          len  = $urandom_range(5, 40);
          for (int k = 0; k < len && sent < PHASE_TICKS; k++) begin
            send_tick(now, goal, 1'b0, 0, 1'b0);
            sent++;
            if (pred_rate == 0) break;
            now = wrap_heading(now + int'((pred_rate * tick_cfg) >>> 16)
                               + int'($urandom_range(0, 16)) - 8);
          end
        end else begin
          now = $urandom_range(0, 2 * HEAD_MAX) - HEAD_MAX;
          if (r < 80) begin
            e = $urandom_range(0, 130);
          end else if (r < 90) begin
            e = zero_div_error();
          end else begin
            e = 0;
          end
          if ($urandom_range(0, 1)) e = -e;
          if (r < 90) begin
            send_tick(now, wrap_heading(now + e), 1'b0, 0, 1'b0);
          end else begin
            send_tick(raw_heading(), raw_heading(), 1'b0, 0, 1'b0);
          end
          sent++;
        end
      end
    end

    settle();
    repeat (50) @(posedge clk);
    $display("%0d ticks, %0d results, %0d register writes in %0d cycles",
             ticks_sent, results_seen, reg_writes, cycle_count);
    $display("accel %0d, corrected %0d (%0d zero div), plain %0d, done %0d, saturated %0d",
             n_accel, n_corr, n_zdiv, n_plain, n_done, n_sat);
    if (errors == 0) begin
      $display("tb_rotate_in_place_rate_profile passed");
    end else begin
      $display("tb_rotate_in_place_rate_profile failed");
    end
    $finish;
  end

  // receiver: random ready gaps, one long hold to back the block up
  initial begin : sink
    int        hold;
    bit        quiet;
    rate_cmd_t want;
    hold  = 0;
    quiet = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        results_seen++;
        if (cmd_queue.size() == 0) begin
          $error("rate command 0x%h arrived with no tick outstanding", m_tdata);
          errors++;
        end else begin
          want = cmd_queue.pop_front();
          if (m_tdata !== want.rate) begin
            $error("rate_command: expected %0d, actual %0d", want.rate, $signed(m_tdata));
            errors++;
          end
          if (m_tuser !== want.done) begin
            $error("rotation_done: expected %0b, actual %0b", want.done, m_tuser);
            errors++;
          end
        end
        if (results_seen == HOLD_AT) hold = LONG_HOLD;
      end
      if ($urandom_range(0, 99) == 0) quiet = !quiet;
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        hold = pick_gap(quiet);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_rotate_in_place_rate_profile failed");
    $finish;
  end

endmodule

/* rotate_in_place_rate_profile.f */
hw/rtl/ripr_pkg.sv
hw/rtl/rotate_in_place_rate_profile.sv
dv/tb_rotate_in_place_rate_profile.sv
